// ----- sv/ble_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_pkg
// Shared constants, codes and the control word for the bounded list engine.
// ----------------------------------------------------------------------------
package ble_pkg;

   localparam int MAX_ENTRIES = 128;
   localparam int IDX_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int CNT_W = IDX_W + 1;
   localparam int CMP_W = (CNT_W > 8) ? CNT_W : 8;

   localparam logic [2:0] CMD_INSERT = 3'd0;
   localparam logic [2:0] CMD_UPDATE = 3'd1;
   localparam logic [2:0] CMD_REMOVE = 3'd2;
   localparam logic [2:0] CMD_FIND   = 3'd3;
   localparam logic [2:0] CMD_SORT   = 3'd4;

   localparam logic [1:0] STAT_OK        = 2'd0;
   localparam logic [1:0] STAT_FULL      = 2'd1;
   localparam logic [1:0] STAT_BAD_POS   = 2'd2;
   localparam logic [1:0] STAT_NOT_FOUND = 2'd3;

   localparam logic [1:0] OP_HOLD  = 2'd0;
   localparam logic [1:0] OP_WRITE = 2'd1;
   localparam logic [1:0] OP_SHIFT = 2'd2;
   localparam logic [1:0] OP_SORT  = 2'd3;

   localparam logic [7:0] CAP_RESET = 8'd100;
   localparam logic [7:0] NO_INDEX  = 8'hFF;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] waddr;
      logic [31:0]      wdata;
      logic [31:0]      key;
      logic [CNT_W-1:0] count;
      logic             phase;
      logic             clear;
   } ble_ctrl_type;

endpackage

// ----- sv/ble_cell.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_cell
// One list slot: holds an entry, joins the match chain and the sort network.
// ----------------------------------------------------------------------------
module ble_cell
   import ble_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ble_ctrl_type     ctrl,
   input  logic [IDX_W-1:0] cell_index,
   input  logic [31:0]      left_value,
   input  logic [31:0]      right_value,
   input  logic             left_gt,
   input  logic             left_prior,
   input  logic [IDX_W-1:0] left_idx,
   output logic [31:0]      value,
   output logic             gt_right,
   output logic             prior_out,
   output logic [IDX_W-1:0] idx_out
);

   logic [31:0]      value_ff, value_in;
   logic             prior_ff, prior_in;
   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             active, right_active, match, is_left;

   assign active       = {1'b0, cell_index} < ctrl.count;
   assign right_active = ({1'b0, cell_index} + CNT_W'(1)) < ctrl.count;
   assign match        = active && (value_ff == ctrl.key);
   assign prior_out    = prior_ff || match;
   assign idx_out      = prior_ff ? idx_ff : cell_index;
   assign gt_right     = right_active && ($signed(value_ff) > $signed(right_value));
   assign is_left      = cell_index[0] == ctrl.phase;
   assign value        = value_ff;

   always_comb begin
      value_in = value_ff;
      unique case (ctrl.op)
         OP_WRITE: begin
            if (ctrl.waddr == cell_index) value_in = ctrl.wdata;
         end
         OP_SHIFT: begin
            if (prior_out) value_in = right_value;
         end
         OP_SORT: begin
            if (is_left && gt_right) value_in = right_value;
            else if (!is_left && left_gt) value_in = left_value;
         end
         default: value_in = value_ff;
      endcase
      prior_in = ctrl.clear ? 1'b0 : left_prior;
      idx_in   = left_idx;
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
      idx_ff   <= idx_in;
      if (reset) prior_ff <= 1'b0;
      else prior_ff <= prior_in;
   end

endmodule

// ----- sv/ble_chain.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ble_chain
// Row of list cells wired to their neighbors; the tail reports the search.
// ----------------------------------------------------------------------------
module ble_chain
   import ble_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ble_ctrl_type     ctrl,
   output logic             hit,
   output logic [IDX_W-1:0] hit_idx
);

   logic [31:0]      val [MAX_ENTRIES];
   logic             gt  [MAX_ENTRIES];
   logic             pri [MAX_ENTRIES];
   logic [IDX_W-1:0] idx [MAX_ENTRIES];

   for (genvar i = 0; i < MAX_ENTRIES; i++) begin : g_cell
      ble_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctrl        (ctrl),
         .cell_index  (IDX_W'(i)),
         .left_value  ((i == 0) ? 32'd0 : val[(i == 0) ? 0 : i - 1]),
         .right_value ((i == MAX_ENTRIES - 1) ? 32'd0
                                              : val[(i == MAX_ENTRIES - 1) ? i : i + 1]),
         .left_gt     ((i == 0) ? 1'b0 : gt[(i == 0) ? 0 : i - 1]),
         .left_prior  ((i == 0) ? 1'b0 : pri[(i == 0) ? 0 : i - 1]),
         .left_idx    ((i == 0) ? '0 : idx[(i == 0) ? 0 : i - 1]),
         .value       (val[i]),
         .gt_right    (gt[i]),
         .prior_out   (pri[i]),
         .idx_out     (idx[i])
      );
   end

   assign hit     = pri[MAX_ENTRIES-1];
   assign hit_idx = idx[MAX_ENTRIES-1];

endmodule

// ----- sv/bounded_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bounded_list_engine
// Bounded list of signed words with insert, update, remove, find and sort.
// ----------------------------------------------------------------------------
//  channel   | ports                          | handshake
//  request   | req_cmd, req_position, req_value | start & !busy
//  response  | rsp_* fields                   | rsp_valid, one cycle, no stall
//  config    | csr_data                       | csr_valid & csr_ready
//
// Insert, update and unknown commands answer in the cycle after start.
// Remove, find and sort step through the cell row, set by the match chain and
// the odd-even transposition network, then answer next cycle.
// Reset is synchronous; it clears the count and loads capacity 100.
// The response cannot be held off; a new word may start in its cycle.
// ----------------------------------------------------------------------------
module bounded_list_engine
   import ble_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   output logic        busy,
   input  logic [2:0]  req_cmd,
   input  logic [6:0]  req_position,
   input  logic [31:0] req_value,
   output logic        rsp_valid,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_found_index,
   output logic [7:0]  rsp_entry_count,
   output logic        rsp_is_empty,
   output logic        rsp_is_full,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [7:0]  csr_data
);

   localparam logic ST_IDLE = 1'b0;
   localparam logic ST_RUN  = 1'b1;

   logic             state_ff, state_in;
   logic [IDX_W-1:0] step_ff, step_in;
   logic [2:0]       cmd_ff, cmd_in;
   logic [31:0]      key_ff, key_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       cap_ff, cap_in;
   logic             vld_ff, vld_in;
   logic [1:0]       stat_ff, stat_in;
   logic [7:0]       found_ff, found_in;
   ble_ctrl_type     ctrl;
   logic             hit, accept, full, last;
   logic [IDX_W-1:0] hit_idx;

   assign busy      = state_ff == ST_RUN;
   assign csr_ready = !busy;
   assign accept    = start && !busy;
   assign full      = (CMP_W'(count_ff) >= CMP_W'(cap_ff)) || (count_ff == CNT_W'(MAX_ENTRIES));
   assign last      = step_ff == IDX_W'(MAX_ENTRIES - 1);

   ble_chain u_chain (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (ctrl),
      .hit     (hit),
      .hit_idx (hit_idx)
   );

   always_comb begin
      state_in = state_ff;
      step_in  = step_ff;
      cmd_in   = cmd_ff;
      key_in   = key_ff;
      count_in = count_ff;
      cap_in   = (csr_valid && csr_ready) ? csr_data : cap_ff;
      vld_in   = 1'b0;
      stat_in  = stat_ff;
      found_in = found_ff;
      ctrl.op    = OP_HOLD;
      ctrl.waddr = '0;
      ctrl.wdata = req_value;
      ctrl.key   = key_ff;
      ctrl.count = count_ff;
      ctrl.phase = step_ff[0];
      ctrl.clear = accept;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd_in   = req_cmd;
               key_in   = req_value;
               step_in  = '0;
               stat_in  = STAT_OK;
               found_in = NO_INDEX;
               unique case (req_cmd)
                  CMD_INSERT: begin
                     vld_in = 1'b1;
                     if (full) stat_in = STAT_FULL;
                     else begin
                        ctrl.op    = OP_WRITE;
                        ctrl.waddr = IDX_W'(count_ff);
                        count_in   = count_ff + CNT_W'(1);
                     end
                  end
                  CMD_UPDATE: begin
                     vld_in = 1'b1;
                     if (CMP_W'(req_position) >= CMP_W'(count_ff)) stat_in = STAT_BAD_POS;
                     else begin
                        ctrl.op    = OP_WRITE;
                        ctrl.waddr = IDX_W'(req_position);
                     end
                  end
                  CMD_REMOVE, CMD_FIND, CMD_SORT: state_in = ST_RUN;
                  default: vld_in = 1'b1;
               endcase
            end
         end
         ST_RUN: begin
            step_in = step_ff + IDX_W'(1);
            if (cmd_ff == CMD_SORT) ctrl.op = OP_SORT;
            if (last) begin
               state_in = ST_IDLE;
               vld_in   = 1'b1;
               unique case (cmd_ff)
                  CMD_REMOVE: begin
                     if (hit) begin
                        ctrl.op  = OP_SHIFT;
                        count_in = count_ff - CNT_W'(1);
                     end else stat_in = STAT_NOT_FOUND;
                  end
                  CMD_FIND: begin
                     if (hit) found_in = 8'(hit_idx);
                     else stat_in = STAT_NOT_FOUND;
                  end
                  default: stat_in = STAT_OK;
               endcase
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      step_ff  <= step_in;
      cmd_ff   <= cmd_in;
      key_ff   <= key_in;
      stat_ff  <= stat_in;
      found_ff <= found_in;
      if (reset) begin
         state_ff <= ST_IDLE;
         count_ff <= '0;
         cap_ff   <= CAP_RESET;
         vld_ff   <= 1'b0;
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         cap_ff   <= cap_in;
         vld_ff   <= vld_in;
      end
   end

   assign rsp_valid       = vld_ff;
   assign rsp_status      = stat_ff;
   assign rsp_found_index = found_ff;
   assign rsp_entry_count = 8'(count_ff);
   assign rsp_is_empty    = count_ff == '0;
   assign rsp_is_full     = full;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_ENTRIES)) else $error("count beyond storage");
   a_scan_starts: assert property (@(posedge clock) disable iff (reset)
      accept && (req_cmd == CMD_FIND || req_cmd == CMD_REMOVE || req_cmd == CMD_SORT)
      |=> busy) else $error("scan did not start");
   a_scan_ends: assert property (@(posedge clock) disable iff (reset)
      busy && last |=> rsp_valid && !busy) else $error("scan did not answer");
   a_found_ok: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_found_index != NO_INDEX |-> rsp_status == STAT_OK)
      else $error("index with bad status");
`endif

endmodule

// ----- tb/tb_bounded_list_engine.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_bounded_list_engine
// Self-checking bench for the bounded list engine. A driver sends command
// words from a queue with random gaps. A monitor compares every response
// with a behavioral list model. The capacity register is rewritten between
// phases while the engine is idle.
// ----------------------------------------------------------------------------
module tb_bounded_list_engine
   import ble_pkg::*;
();

   typedef struct packed {
      logic [2:0]  cmd;
      logic [6:0]  position;
      logic [31:0] value;
   } list_cmd_type;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] found_index;
      logic [7:0] entry_count;
      logic       is_empty;
      logic       is_full;
   } list_rsp_type;

   localparam int WATCHDOG_LIMIT = 20000;

   logic        clock;
   logic        reset;
   logic        start;
   logic        busy;
   logic [2:0]  req_cmd;
   logic [6:0]  req_position;
   logic [31:0] req_value;
   logic        rsp_valid;
   logic [1:0]  rsp_status;
   logic [7:0]  rsp_found_index;
   logic [7:0]  rsp_entry_count;
   logic        rsp_is_empty;
   logic        rsp_is_full;
   logic        csr_valid;
   logic        csr_ready;
   logic [7:0]  csr_data;

   list_cmd_type pending_cmds[$];
   list_rsp_type expected_rsps[$];
   logic [31:0]  model_entries[MAX_ENTRIES];
   int           model_count;
   int           model_capacity;
   int           error_count;
   int           idle_cycles;
   int           gap_left;
   int           sent_count;

   bounded_list_engine dut (.*);

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic list_rsp_type apply_list_cmd(list_cmd_type c);
      list_rsp_type r;
      int        eff_cap;
      int        hit;
      logic [31:0] v;
      int        j;
      eff_cap = (model_capacity < MAX_ENTRIES) ? model_capacity : MAX_ENTRIES;
      r.status = STAT_OK;
      r.found_index = NO_INDEX;
      hit = model_count;
      for (int i = model_count - 1; i >= 0; i--) begin
         if (model_entries[i] == c.value) hit = i;
      end
      case (c.cmd)
         CMD_INSERT: begin
            if (model_count >= eff_cap) r.status = STAT_FULL;
            else begin
               model_entries[model_count] = c.value;
               model_count++;
            end
         end
         CMD_UPDATE: begin
            if (c.position >= model_count) r.status = STAT_BAD_POS;
            else model_entries[c.position] = c.value;
         end
         CMD_REMOVE: begin
            if (hit >= model_count) r.status = STAT_NOT_FOUND;
            else begin
               for (int i = hit; i + 1 < model_count; i++)
                  model_entries[i] = model_entries[i + 1];
               model_count--;
            end
         end
         CMD_FIND: begin
            if (hit >= model_count) r.status = STAT_NOT_FOUND;
            else r.found_index = hit[7:0];
         end
         CMD_SORT: begin
            for (int i = 1; i < model_count; i++) begin
               v = model_entries[i];
               j = i;
               while (j > 0 && $signed(model_entries[j - 1]) > $signed(v)) begin
                  model_entries[j] = model_entries[j - 1];
                  j--;
               end
               model_entries[j] = v;
            end
         end
         default: ;
      endcase
      r.entry_count = model_count[7:0];
      r.is_empty = (model_count == 0);
      r.is_full = (model_count >= eff_cap);
      return r;
   endfunction

   task automatic report_mismatch(string what, int got, int want);
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $realtime);
      error_count++;
   endtask

   // Driver: one word from the queue after a random gap.
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
         gap_left <= $urandom_range(0, 18);
      end else if (start && !busy) begin
         start <= 1'b0;
         sent_count <= sent_count + 1;
         expected_rsps = {expected_rsps,
                          apply_list_cmd({req_cmd, req_position, req_value})};
         gap_left <= $urandom_range(0, 18);
      end else if (!start && pending_cmds.size() > 0) begin
         if (gap_left > 0) gap_left <= gap_left - 1;
         else begin
            start <= 1'b1;
            req_cmd <= pending_cmds[0].cmd;
            req_position <= pending_cmds[0].position;
            req_value <= pending_cmds[0].value;
            void'(pending_cmds.pop_front());
         end
      end
   end

   // Monitor and watchdog.
   always @(posedge clock) begin
      list_rsp_type want;
      if (reset) idle_cycles <= 0;
      else begin
         if ((start && !busy) || rsp_valid || (csr_valid && csr_ready)) idle_cycles <= 0;
         else idle_cycles <= idle_cycles + 1;
         if (idle_cycles > WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
         if (rsp_valid) begin
            if (expected_rsps.size() == 0) report_mismatch("unexpected word", 1, 0);
            else begin
               want = expected_rsps.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", rsp_status, want.status);
               if (rsp_found_index !== want.found_index)
                  report_mismatch("found_index", rsp_found_index, want.found_index);
               if (rsp_entry_count !== want.entry_count)
                  report_mismatch("entry_count", rsp_entry_count, want.entry_count);
               if (rsp_is_empty !== want.is_empty)
                  report_mismatch("is_empty", rsp_is_empty, want.is_empty);
               if (rsp_is_full !== want.is_full)
                  report_mismatch("is_full", rsp_is_full, want.is_full);
            end
         end
      end
   end

   task automatic write_capacity(int cap);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_data <= cap[7:0];
      do @(posedge clock); while (!csr_ready);
      model_capacity = cap;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_cmds.size() > 0 || start || expected_rsps.size() > 0)
         @(posedge clock);
      repeat (MAX_ENTRIES + 8) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_value();
      int k;
      k = $urandom_range(0, 9);
      if (k < 6) return $urandom_range(0, 15) - 8;
      if (k == 6) return 32'h8000_0000;
      if (k == 7) return 32'h7fff_ffff;
      if (k == 8 && model_count > 0) return model_entries[$urandom_range(0, model_count - 1)];
      return $urandom;
   endfunction

   task automatic queue_random(int n);
      list_cmd_type c;
      int        k;
      for (int i = 0; i < n; i++) begin
         k = $urandom_range(0, 19);
         if (k < 8) c.cmd = CMD_INSERT;
         else if (k < 11) c.cmd = CMD_UPDATE;
         else if (k < 14) c.cmd = CMD_REMOVE;
         else if (k < 17) c.cmd = CMD_FIND;
         else if (k < 19) c.cmd = CMD_SORT;
         else c.cmd = 3'($urandom_range(5, 7));
         c.position = ($urandom_range(0, 3) == 0) ? 7'($urandom)
                                                  : 7'($urandom_range(0, 40));
         c.value = $urandom_range(0, 1) ? pick_value() : $urandom;
         pending_cmds = {pending_cmds, c};
         wait_drained_if_needed();
      end
   endtask

   // The model needs the live count for value picks, so fill in small bursts.
   task automatic wait_drained_if_needed();
      if (pending_cmds.size() > 4)
         while (pending_cmds.size() > 1) @(posedge clock);
   endtask

   task automatic queue_cmd(logic [2:0] cmd, logic [6:0] pos, logic [31:0] val);
      list_cmd_type c;
      c = {cmd, pos, val};
      pending_cmds = {pending_cmds, c};
   endtask

   initial begin
      int caps[6];
      caps = '{0, 1, 128, 255, 5, 60};
      error_count = 0;
      sent_count = 0;
      model_count = 0;
      model_capacity = int'(CAP_RESET);
      reset = 1'b1;
      start = 1'b0;
      req_cmd = '0;
      req_position = '0;
      req_value = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      queue_cmd(CMD_FIND, 7'd0, 32'd5);
      queue_cmd(CMD_REMOVE, 7'd0, 32'd5);
      queue_cmd(CMD_UPDATE, 7'd0, 32'd1);
      queue_cmd(CMD_SORT, 7'd0, 32'd0);
      queue_cmd(CMD_INSERT, 7'd0, 32'h7fff_ffff);
      queue_cmd(CMD_INSERT, 7'd0, 32'h8000_0000);
      queue_cmd(CMD_INSERT, 7'd0, 32'd0);
      queue_cmd(CMD_INSERT, 7'd0, 32'hffff_ffff);
      queue_cmd(CMD_INSERT, 7'd0, 32'h8000_0000);
      queue_cmd(CMD_SORT, 7'd0, 32'd0);
      queue_cmd(CMD_FIND, 7'd0, 32'h8000_0000);
      queue_cmd(CMD_FIND, 7'd0, 32'h7fff_ffff);
      queue_cmd(CMD_UPDATE, 7'd4, 32'd9);
      queue_cmd(CMD_UPDATE, 7'd5, 32'd9);
      queue_cmd(CMD_UPDATE, 7'd127, 32'd9);
      queue_cmd(CMD_REMOVE, 7'd0, 32'h8000_0000);
      queue_cmd(CMD_REMOVE, 7'd0, 32'd77);
      queue_cmd(3'd5, 7'h7f, 32'hffff_ffff);
      queue_cmd(3'd7, 7'd0, 32'd0);
      wait_drained();
      write_capacity(2);
      queue_cmd(CMD_INSERT, 7'd0, 32'd3);
      queue_cmd(CMD_FIND, 7'd0, 32'd3);
      wait_drained();

      for (int p = 0; p < 6; p++) begin
         write_capacity(caps[p]);
         queue_random(110);
         wait_drained();
      end
      write_capacity(200);
      for (int i = 0; i < 130; i++) queue_cmd(CMD_INSERT, 7'($urandom), $urandom);
      queue_cmd(CMD_SORT, 7'd0, 32'd0);
      queue_cmd(CMD_FIND, 7'd0, 32'h7fff_ffff);
      wait_drained();

      if (error_count == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
